>>> src/mma_pkg.sv
// ----------------------------------------------------------------------------
// mma_pkg
// Shared types and constants of the Montgomery modular arithmetic core.
// ----------------------------------------------------------------------------
package mma_pkg;

  // Fixed field widths of the ports.
  localparam int DATA_W    = 31;
  localparam int INT_W     = 64;
  localparam int OP_W      = 4;
  localparam int CFG_IDX_W = 3;
  localparam int MB_W      = 5;

  // Widest possible R mask: mont_bits is a five-bit count below 32.
  localparam int QW = 31;

  // Opcodes.
  typedef enum logic [OP_W-1:0] {
    OP_TO_MONT   = 4'd0,
    OP_FROM_MONT = 4'd1,
    OP_ADD       = 4'd2,
    OP_SUB       = 4'd3,
    OP_NEG       = 4'd4,
    OP_MUL       = 4'd5,
    OP_POW       = 4'd6,
    OP_INV       = 4'd7,
    OP_DIV       = 4'd8,
    OP_EQUAL     = 4'd9
  } op_t;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MONT_BITS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEG_INVERSE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_R_SQUARED   = 3'd3;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_SIGN,
    S_MUL,
    S_RQ,
    S_RM,
    S_RFIN,
    S_LOOP
  } state_t;

  // What happens with the result of a Montgomery reduction.
  typedef enum logic [1:0] {
    PH_OUT,
    PH_ONE,
    PH_ACC,
    PH_SQR
  } phase_t;

endpackage

>>> src/montgomery_modular_alu_core.sv
// ----------------------------------------------------------------------------
// montgomery_modular_alu_core
// Modular arithmetic on Montgomery-form values with a bit-serial multiplier.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; its result appears for
// one cycle with done high, and the receiver cannot stall it. Add, sub, neg,
// equal and unused opcodes register their result in the cycle after the word
// is taken. Every Montgomery multiply runs the one shift-add multiplier three
// times, one bit per cycle, then shifts and reduces in S_RFIN (from_mont skips
// the first product). to_mont runs a restoring remainder and a sign step
// before one multiply. pow, inv and div take one multiply for the start value
// and up to two per exponent bit, up to 63 bits, plus a loop test per bit and
// one more when the exponent runs out; div ends with one more multiply.
module montgomery_modular_alu_core #(
  parameter int MOD_BITS = 31
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [mma_pkg::OP_W-1:0]        operation,
  input  logic [mma_pkg::DATA_W-1:0]      operand_a,
  input  logic [mma_pkg::DATA_W-1:0]      operand_b,
  input  logic signed [mma_pkg::INT_W-1:0] integer_in,
  output logic                            done,
  output logic [mma_pkg::DATA_W-1:0]      result,
  output logic                            is_equal,
  input  logic                            cfg_write,
  input  logic [mma_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mma_pkg::DATA_W-1:0]      cfg_data
);
  import mma_pkg::*;

  localparam int W  = MOD_BITS;
  localparam int PW = QW + W;
  localparam int SW = PW + 1;
  localparam int CW = $clog2(QW);

  // Configuration registers.
  logic [W-1:0]      modulus;
  logic [MB_W-1:0]   mont_bits;
  logic [W-1:0]      neg_inverse;
  logic [W-1:0]      r_squared;

  // Sequencer and working registers.
  state_t            state, state_next;
  phase_t            phase;
  op_t               op_reg;
  logic [W-1:0]      a_reg, acc, base;
  logic [INT_W-1:0]  expo;
  logic [INT_W-1:0]  div_num;
  logic              div_neg;
  logic [W-1:0]      rem;
  logic [5:0]        div_cnt;
  logic [PW-1:0]     t_reg;
  logic [SW-1:0]     sum_reg;

  // Shift-add multiplier.
  logic [W-1:0]      mul_hi;
  logic [QW-1:0]     mul_lo;
  logic [W-1:0]      mul_y;
  logic [CW-1:0]     mul_cnt;

  // Result word.
  logic [W-1:0]      res_reg;
  logic              eq_reg;
  logic              done_reg;

  // Input fields at working width.
  logic [W-1:0]      a_in, b_in;
  op_t               op_in;
  logic              op_known;

  assign a_in = operand_a[W-1:0];
  assign b_in = operand_b[W-1:0];
  assign op_known = (operation <= OP_W'(OP_EQUAL));
  assign op_in = op_known ? op_t'(operation) : OP_ADD;

  // One multiplier step: add y when the low bit is set, then shift right.
  logic [W:0]        mul_sum;
  logic [PW-1:0]     prod_step;
  logic              mul_last;

  assign mul_sum   = {1'b0, mul_hi} + {1'b0, (mul_lo[0] ? mul_y : W'(0))};
  assign prod_step = {mul_sum[W:1], mul_sum[0], mul_lo[QW-1:1]};
  assign mul_last  = (mul_cnt == CW'(QW - 1));

  // Mask of R and the low part of a product under it.
  logic [QW-1:0]     rmask;
  logic [QW-1:0]     q_val;

  assign rmask = ~({QW{1'b1}} << mont_bits);
  assign q_val = prod_step[QW-1:0] & rmask;

  // Final shift and conditional subtraction of the reduction.
  logic [SW-1:0]     red_sh;
  logic [SW-1:0]     red_sub;
  logic [W-1:0]      red_val;

  assign red_sh  = sum_reg >> mont_bits;
  assign red_sub = (red_sh >= SW'(modulus)) ? (red_sh - SW'(modulus)) : red_sh;
  assign red_val = red_sub[W-1:0];

  // One restoring division step on the 64-bit magnitude.
  logic [W:0]        div_rs;
  logic [W:0]        div_rn;

  assign div_rs = {rem, div_num[INT_W-1]};
  assign div_rn = (div_rs >= {1'b0, modulus}) ? (div_rs - {1'b0, modulus}) : div_rs;

  // Residue after the sign fix, and the residue of one.
  logic [W-1:0]      sign_res;
  logic [W-1:0]      one_res;

  assign sign_res = (modulus == W'(0)) ? W'(0) :
                    ((div_neg && rem != W'(0)) ? (modulus - rem) : rem);
  assign one_res  = (modulus <= W'(1)) ? W'(0) : W'(1);

  // Operations computed straight from the inputs.
  logic [W:0]        add_s;
  logic [W-1:0]      add_res, sub_res, neg_res;
  logic [W-1:0]      ca, cb;

  assign add_s   = {1'b0, a_in} + {1'b0, b_in};
  assign add_res = (add_s >= {1'b0, modulus}) ? W'(add_s - {1'b0, modulus}) : add_s[W-1:0];
  assign sub_res = (a_in - b_in) + ((a_in < b_in) ? modulus : W'(0));
  assign neg_res = (W'(0) - a_in) + ((a_in != W'(0)) ? modulus : W'(0));
  assign ca      = (a_in >= modulus) ? (a_in - modulus) : a_in;
  assign cb      = (b_in >= modulus) ? (b_in - modulus) : b_in;

  // Exponent loop test.
  logic              loop_end;

  assign loop_end = expo[INT_W-1] || (expo == INT_W'(0));

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus     <= W'(3);
      mont_bits   <= MB_W'(2);
      neg_inverse <= W'(1);
      r_squared   <= W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MODULUS:     modulus     <= cfg_data[W-1:0];
        REG_MONT_BITS:   mont_bits   <= cfg_data[MB_W-1:0];
        REG_NEG_INVERSE: neg_inverse <= cfg_data[W-1:0];
        REG_R_SQUARED:   r_squared   <= cfg_data[W-1:0];
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start && op_known) begin
          unique case (op_in)
            OP_TO_MONT:   state_next = S_DIV;
            OP_FROM_MONT: state_next = S_RQ;
            OP_MUL, OP_POW, OP_INV, OP_DIV: state_next = S_MUL;
            default:      state_next = S_IDLE;
          endcase
        end
      end
      S_DIV:  if (div_cnt == 6'd63) state_next = S_SIGN;
      S_SIGN: state_next = S_MUL;
      S_MUL:  if (mul_last) state_next = S_RQ;
      S_RQ:   if (mul_last) state_next = S_RM;
      S_RM:   if (mul_last) state_next = S_RFIN;
      S_RFIN: begin
        unique case (phase)
          PH_OUT:  state_next = S_IDLE;
          PH_ONE:  state_next = S_LOOP;
          PH_ACC:  state_next = S_MUL;
          PH_SQR:  state_next = S_LOOP;
          default: state_next = S_IDLE;
        endcase
      end
      S_LOOP: begin
        if (loop_end && op_reg != OP_DIV) state_next = S_IDLE;
        else state_next = S_MUL;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Outputs.
  always_comb begin
    busy     = (state != S_IDLE);
    done     = done_reg;
    result   = DATA_W'(res_reg);
    is_equal = eq_reg;
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      done_reg <= 1'b0;
      res_reg  <= W'(0);
      eq_reg   <= 1'b0;
    end else begin
      done_reg <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_reg <= op_in;
            a_reg  <= a_in;
            eq_reg <= 1'b0;
            mul_hi  <= W'(0);
            mul_cnt <= CW'(0);
            if (!op_known) begin
              res_reg  <= W'(0);
              done_reg <= 1'b1;
            end else begin
              unique case (op_in)
                OP_TO_MONT: begin
                  div_num <= integer_in[INT_W-1] ? (INT_W'(0) - integer_in) : integer_in;
                  div_neg <= integer_in[INT_W-1];
                  rem     <= W'(0);
                  div_cnt <= 6'd0;
                end
                OP_FROM_MONT: begin
                  t_reg  <= PW'(a_in);
                  mul_lo <= QW'(a_in) & rmask;
                  mul_y  <= neg_inverse;
                  phase  <= PH_OUT;
                end
                OP_ADD: begin
                  res_reg  <= add_res;
                  done_reg <= 1'b1;
                end
                OP_SUB: begin
                  res_reg  <= sub_res;
                  done_reg <= 1'b1;
                end
                OP_NEG: begin
                  res_reg  <= neg_res;
                  done_reg <= 1'b1;
                end
                OP_MUL: begin
                  mul_lo <= QW'(a_in);
                  mul_y  <= b_in;
                  phase  <= PH_OUT;
                end
                OP_POW, OP_INV, OP_DIV: begin
                  if (op_in == OP_POW) expo <= integer_in;
                  else expo <= INT_W'(modulus) - INT_W'(2);
                  base   <= (op_in == OP_DIV) ? b_in : a_in;
                  mul_lo <= QW'(one_res);
                  mul_y  <= r_squared;
                  phase  <= PH_ONE;
                end
                OP_EQUAL: begin
                  res_reg  <= W'(0);
                  eq_reg   <= (ca == cb);
                  done_reg <= 1'b1;
                end
                default: ;
              endcase
            end
          end
        end

        // Remainder of the magnitude, one numerator bit per cycle.
        S_DIV: begin
          div_num <= {div_num[INT_W-2:0], 1'b0};
          rem     <= div_rn[W-1:0];
          div_cnt <= div_cnt + 6'd1;
        end

        // Sign fix, then multiply by R squared.
        S_SIGN: begin
          mul_hi  <= W'(0);
          mul_lo  <= QW'(sign_res);
          mul_y   <= r_squared;
          mul_cnt <= CW'(0);
          phase   <= PH_OUT;
        end

        // Product T of the two operands.
        S_MUL: begin
          mul_cnt <= mul_cnt + CW'(1);
          if (mul_last) begin
            t_reg   <= prod_step;
            mul_hi  <= W'(0);
            mul_lo  <= prod_step[QW-1:0] & rmask;
            mul_y   <= neg_inverse;
            mul_cnt <= CW'(0);
          end else begin
            mul_hi <= prod_step[PW-1:QW];
            mul_lo <= prod_step[QW-1:0];
          end
        end

        // Quotient q of the low part of T times the negative inverse.
        S_RQ: begin
          mul_cnt <= mul_cnt + CW'(1);
          if (mul_last) begin
            mul_hi  <= W'(0);
            mul_lo  <= q_val;
            mul_y   <= modulus;
            mul_cnt <= CW'(0);
          end else begin
            mul_hi <= prod_step[PW-1:QW];
            mul_lo <= prod_step[QW-1:0];
          end
        end

        // q times the modulus, then add T.
        S_RM: begin
          mul_cnt <= mul_cnt + CW'(1);
          if (mul_last) begin
            sum_reg <= {1'b0, prod_step} + {1'b0, t_reg};
          end else begin
            mul_hi <= prod_step[PW-1:QW];
            mul_lo <= prod_step[QW-1:0];
          end
        end

        // Shift by R, reduce once and hand the value on.
        S_RFIN: begin
          unique case (phase)
            PH_OUT: begin
              res_reg  <= red_val;
              done_reg <= 1'b1;
            end
            PH_ONE: acc <= red_val;
            PH_ACC: begin
              acc     <= red_val;
              mul_hi  <= W'(0);
              mul_lo  <= QW'(base);
              mul_y   <= base;
              mul_cnt <= CW'(0);
              phase   <= PH_SQR;
            end
            PH_SQR: begin
              base <= red_val;
              expo <= expo >> 1;
            end
            default: ;
          endcase
        end

        // Square-and-multiply decision for the next exponent bit.
        S_LOOP: begin
          mul_hi  <= W'(0);
          mul_cnt <= CW'(0);
          if (loop_end) begin
            if (op_reg == OP_DIV) begin
              mul_lo <= QW'(a_reg);
              mul_y  <= acc;
              phase  <= PH_OUT;
            end else begin
              res_reg  <= acc;
              done_reg <= 1'b1;
            end
          end else if (expo[0]) begin
            mul_lo <= QW'(acc);
            mul_y  <= base;
            phase  <= PH_ACC;
          end else begin
            mul_lo <= QW'(base);
            mul_y  <= base;
            phase  <= PH_SQR;
          end
        end

        default: ;
      endcase
    end
  end

endmodule

>>> sim/tb_montgomery_modular_alu_core.sv
// ----------------------------------------------------------------------------
// tb_montgomery_modular_alu_core
// Self-checking testbench of the Montgomery modular arithmetic core.
// ----------------------------------------------------------------------------
// A queue of pending words (operations and register writes) is filled up
// front. A clocked driver issues them with random gaps, and a clocked monitor
// compares every result with the value that a built-in predictor of the
// modular arithmetic worked out when the word was accepted. The run steps
// through several register settings: proper prime moduli between the smallest
// and the largest, in mixed order, plus inconsistent and zero-modulus settings.
// ----------------------------------------------------------------------------
module tb_montgomery_modular_alu_core;
  timeunit 1ns;
  timeprecision 1ps;

  import mma_pkg::*;

  localparam longint unsigned VAL_MASK = (64'd1 << DATA_W) - 1;
  localparam longint unsigned CYCLE_LIMIT = 40000000;
  localparam int FIRST_UNUSED_OP = 10;
  localparam int LAST_UNUSED_OP = 15;
  localparam int ITEMS_PER_SETTING = 85;

  // One pending word: either an operation or a register write.
  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [DATA_W-1:0]     data;
    logic [OP_W-1:0]       op;
    logic [DATA_W-1:0]     a;
    logic [DATA_W-1:0]     b;
    logic [INT_W-1:0]      n;
    int                    gap;
  } word_t;

  typedef struct {
    logic [DATA_W-1:0] value;
    logic              eq;
  } outcome_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic [OP_W-1:0]         operation = '0;
  logic [DATA_W-1:0]       operand_a = '0;
  logic [DATA_W-1:0]       operand_b = '0;
  logic signed [INT_W-1:0] integer_in = '0;
  logic                    done;
  logic [DATA_W-1:0]       result;
  logic                    is_equal;
  logic                    cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [DATA_W-1:0]       cfg_data = '0;

  // Predictor copy of the registers.
  longint unsigned m_mod = 3;
  longint unsigned m_bits = 2;
  longint unsigned m_ninv = 1;
  longint unsigned m_r2 = 1;

  word_t    pending_words[$];
  outcome_t awaited_results[$];
  word_t    current_word;
  int       gap_left = 0;
  int       errors = 0;
  int       words_sent = 0;
  int       heavy_sent = 0;
  int       settings_used = 0;
  int       results_seen = 0;
  longint unsigned cycles = 0;
  longint unsigned cur_mod = 3;

  montgomery_modular_alu_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .operand_a(operand_a), .operand_b(operand_b),
    .integer_in(integer_in), .done(done), .result(result), .is_equal(is_equal),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Montgomery reduction with one conditional subtraction.
  function automatic longint unsigned mont_reduce(longint unsigned t);
    longint unsigned rmask, q, r;
    rmask = (64'd1 << (m_bits & 31)) - 1;
    q = ((t & rmask) * m_ninv) & rmask;
    r = (q * m_mod + t) >> (m_bits & 31);
    if (r >= m_mod) r -= m_mod;
    return r & VAL_MASK;
  endfunction

  function automatic longint unsigned mont_mul(longint unsigned x, longint unsigned y);
    return mont_reduce((x & VAL_MASK) * (y & VAL_MASK));
  endfunction

  // Signed 64-bit integer into Montgomery form.
  function automatic longint unsigned to_mont_form(longint unsigned raw);
    longint unsigned mag, res;
    mag = raw[63] ? (64'd0 - raw) : raw;
    res = 0;
    if (m_mod != 0) begin
      res = mag % m_mod;
      if (raw[63] && res != 0) res = m_mod - res;
    end
    return mont_mul(res, m_r2);
  endfunction

  function automatic longint unsigned mod_sub(longint unsigned x, longint unsigned y);
    longint unsigned d;
    d = x - y;
    if (x < y) d += m_mod;
    return d & VAL_MASK;
  endfunction

  // Square-and-multiply; a negative exponent yields one.
  function automatic longint unsigned mod_pow(longint unsigned base, longint unsigned e);
    longint unsigned acc, sq;
    acc = to_mont_form(1);
    sq = base & VAL_MASK;
    if (e[63]) return acc;
    while (e != 0) begin
      if (e[0]) acc = mont_mul(acc, sq);
      sq = mont_mul(sq, sq);
      e >>= 1;
    end
    return acc;
  endfunction

  function automatic longint unsigned canon(longint unsigned x);
    return (x >= m_mod) ? x - m_mod : x;
  endfunction

  function automatic outcome_t predict_outcome(word_t w);
    outcome_t o;
    longint unsigned a, b, s;
    a = w.a;
    b = w.b;
    o.value = '0;
    o.eq = 1'b0;
    case (w.op)
      OP_TO_MONT:   o.value = to_mont_form(w.n);
      OP_FROM_MONT: o.value = mont_reduce(a);
      OP_ADD: begin
        s = a + b;
        if (s >= m_mod) s -= m_mod;
        o.value = s & VAL_MASK;
      end
      OP_SUB:   o.value = mod_sub(a, b);
      OP_NEG:   o.value = mod_sub(0, a);
      OP_MUL:   o.value = mont_mul(a, b);
      OP_POW:   o.value = mod_pow(a, w.n);
      OP_INV:   o.value = mod_pow(a, m_mod - 2);
      OP_DIV:   o.value = mont_mul(a, mod_pow(b, m_mod - 2));
      OP_EQUAL: o.eq = (canon(a) == canon(b));
      default: ;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, longint unsigned data);
    word_t w;
    w = '{default: '0};
    w.is_cfg = 1'b1;
    w.idx = idx;
    w.data = data[DATA_W-1:0];
    w.gap = pick_gap();
    pending_words.push_back(w);
    if (idx == REG_MODULUS) cur_mod = data & VAL_MASK;
  endtask

  // Consistent registers for an odd modulus.
  task automatic add_setting(longint unsigned md);
    longint unsigned bits, rr, inv;
    bits = 0;
    while ((md >> bits) != 0) bits++;
    rr = 64'd1 << bits;
    inv = md;
    repeat (6) inv = inv * (2 - md * inv);
    add_cfg(REG_MODULUS, md);
    add_cfg(REG_MONT_BITS, bits);
    add_cfg(REG_NEG_INVERSE, (64'd0 - inv) & (rr - 1));
    add_cfg(REG_R_SQUARED, ((rr % md) * (rr % md)) % md);
    settings_used++;
  endtask

  task automatic add_op(logic [OP_W-1:0] op, longint unsigned a, longint unsigned b,
                        longint unsigned n, int gap);
    word_t w;
    w = '{default: '0};
    w.op = op;
    w.a = a[DATA_W-1:0];
    w.b = b[DATA_W-1:0];
    w.n = n;
    w.gap = gap;
    pending_words.push_back(w);
  endtask

  function automatic longint unsigned rand_operand();
    if (cur_mod > 1 && $urandom_range(0, 99) < 85)
      return $urandom_range(0, 32'(cur_mod - 1));
    return $urandom & VAL_MASK;
  endfunction

  function automatic longint unsigned rand_exponent();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, 255);
    if (r < 72) return {1'b1, 31'($urandom), 32'($urandom)};
    if (r < 95) return $urandom_range(0, 65535);
    return {1'b0, 31'($urandom), 32'($urandom)};
  endfunction

  // Random words; idle-free stretches when quiet is set.
  task automatic add_random(int count, bit quiet);
    int r;
    logic [OP_W-1:0] op;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 12) op = OP_TO_MONT;
      else if (r < 22) op = OP_FROM_MONT;
      else if (r < 34) op = OP_ADD;
      else if (r < 46) op = OP_SUB;
      else if (r < 54) op = OP_NEG;
      else if (r < 70) op = OP_MUL;
      else if (r < 80) op = OP_POW;
      else if (r < 83) op = OP_INV;
      else if (r < 86) op = OP_DIV;
      else if (r < 96) op = OP_EQUAL;
      else op = OP_W'($urandom_range(FIRST_UNUSED_OP, LAST_UNUSED_OP));
      add_op(op, rand_operand(), rand_operand(),
             (op == OP_POW) ? rand_exponent() : {32'($urandom), 32'($urandom)},
             quiet ? 0 : pick_gap());
    end
  endtask

  // Driver: issues pending words; register writes only once everything is back.
  always @(posedge clk) begin : drive
    logic nstart;
    logic ncfg;
    outcome_t o;
    nstart = start;
    ncfg = 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        o = predict_outcome(current_word);
        awaited_results.push_back(o);
        words_sent++;
        if (current_word.op inside {OP_POW, OP_INV, OP_DIV}) heavy_sent++;
        nstart = 1'b0;
      end
      if (!nstart) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_words.size() > 0) begin
          if (pending_words[0].is_cfg) begin
            if (awaited_results.size() == 0 && !busy && !cfg_write) begin
              case (pending_words[0].idx)
                REG_MODULUS:     m_mod = pending_words[0].data;
                REG_MONT_BITS:   m_bits = pending_words[0].data & 31;
                REG_NEG_INVERSE: m_ninv = pending_words[0].data;
                REG_R_SQUARED:   m_r2 = pending_words[0].data;
                default: ;
              endcase
              cfg_index <= pending_words[0].idx;
              cfg_data <= pending_words[0].data;
              ncfg = 1'b1;
              gap_left = pending_words[0].gap;
              void'(pending_words.pop_front());
            end
          end else if (!cfg_write) begin
            current_word = pending_words.pop_front();
            operation <= current_word.op;
            operand_a <= current_word.a;
            operand_b <= current_word.b;
            integer_in <= current_word.n;
            gap_left = current_word.gap;
            nstart = 1'b1;
          end
        end
      end
    end
    start <= nstart;
    cfg_write <= ncfg;
  end

  // Monitor: every done cycle carries one result word.
  always @(posedge clk) begin : watch
    outcome_t e;
    if (!rst && done) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d", result));
      end else begin
        e = awaited_results.pop_front();
        if (result !== e.value)
          report_mismatch($sformatf("result %0d, expected %0d", result, e.value));
        if (is_equal !== e.eq)
          report_mismatch($sformatf("is_equal %b, expected %b", is_equal, e.eq));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** montgomery_modular_alu_core: FAILED **");
      $finish;
    end
  end

  initial begin
    longint unsigned mx;
    longint unsigned primes[$];
    mx = 2147483647;
    primes = '{13, 998244353, 65537, 7, 1000000007};

    // Reset-value setting first.
    add_random(40, 1'b0);

    // Directed words at the largest prime.
    add_setting(mx);
    add_op(OP_TO_MONT, 0, 0, 0, 0);
    add_op(OP_TO_MONT, 0, 0, 1, 0);
    add_op(OP_TO_MONT, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    add_op(OP_TO_MONT, 0, 0, 64'h8000_0000_0000_0000, 1);
    add_op(OP_TO_MONT, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF, 0);
    add_op(OP_FROM_MONT, 0, 0, 0, 0);
    add_op(OP_FROM_MONT, mx - 1, 0, 0, 2);
    add_op(OP_ADD, mx - 1, mx - 1, 0, 0);
    add_op(OP_ADD, 0, 0, 0, 0);
    add_op(OP_SUB, 0, mx - 1, 0, 0);
    add_op(OP_SUB, 12345, 12345, 0, 0);
    add_op(OP_NEG, 0, 0, 0, 0);
    add_op(OP_NEG, mx - 1, 0, 0, 0);
    add_op(OP_MUL, mx - 1, mx - 1, 0, 0);
    add_op(OP_POW, 777, 0, 0, 0);
    add_op(OP_POW, 777, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    add_op(OP_POW, 0, 0, 1, 0);
    add_op(OP_POW, mx - 2, 0, 64'h7FFF_FFFF_FFFF_FFFF, 0);
    add_op(OP_INV, 2, 0, 0, 0);
    add_op(OP_INV, 0, 0, 0, 0);
    add_op(OP_DIV, 99, 5, 0, 0);
    add_op(OP_EQUAL, 0, mx, 0, 0);
    add_op(OP_EQUAL, 1, 2, 0, 0);
    add_op(OP_W'(FIRST_UNUSED_OP), 5, 5, 5, 0);
    add_op(OP_W'(LAST_UNUSED_OP), mx, mx, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    add_random(ITEMS_PER_SETTING, 1'b1);

    foreach (primes[i]) begin
      add_setting(primes[i]);
      add_random(ITEMS_PER_SETTING, i[0]);
    end

    // Inconsistent registers, then a zero modulus; stray indexes are ignored.
    add_cfg(REG_MODULUS, $urandom & VAL_MASK);
    add_cfg(REG_MONT_BITS, $urandom_range(0, 31));
    add_cfg(REG_NEG_INVERSE, $urandom & VAL_MASK);
    add_cfg(REG_R_SQUARED, $urandom & VAL_MASK);
    add_cfg(CFG_IDX_W'(4), $urandom);
    add_cfg(CFG_IDX_W'(7), $urandom);
    settings_used++;
    add_random(40, 1'b0);
    add_cfg(REG_MODULUS, 0);
    add_cfg(REG_MONT_BITS, 31);
    add_cfg(REG_NEG_INVERSE, VAL_MASK);
    add_cfg(REG_R_SQUARED, VAL_MASK);
    settings_used++;
    add_random(30, 1'b0);

    // Back to the smallest modulus.
    add_setting(3);
    add_random(40, 1'b0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || start || awaited_results.size() != 0)
      @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Sent %0d words (%0d power, inverse or divide) over %0d register settings.",
             words_sent, heavy_sent, settings_used);
    $display("Checked %0d results, %0d mismatches.", results_seen, errors);
    if (errors == 0 && awaited_results.size() == 0)
      $display("** montgomery_modular_alu_core: PASSED **");
    else
      $display("** montgomery_modular_alu_core: FAILED **");
    $finish;
  end

endmodule

>>> files.f
src/mma_pkg.sv
src/montgomery_modular_alu_core.sv
sim/tb_montgomery_modular_alu_core.sv
